/* hdl/lps_pkg.sv */
package lps_pkg;

  localparam int unsigned LED_W    = 8;
  localparam int unsigned PAT_W    = 3;
  localparam int unsigned STEP_W   = 4;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned IN_TDATA_W  = 8;

  // configuration register indexes
  localparam logic CFG_SHIFT_PERIOD  = 1'b0;
  localparam logic CFG_FLOWER_PERIOD = 1'b1;

  localparam logic [PERIOD_W-1:0] SHIFT_PERIOD_RST  = 10'd100;
  localparam logic [PERIOD_W-1:0] FLOWER_PERIOD_RST = 10'd200;
  localparam logic [PERIOD_W-1:0] MS_MAX            = 10'h3ff;

  // request kinds (in_tuser)
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // pattern codes
  localparam logic [PAT_W-1:0] PAT_DOT_LEFT    = 3'd0;
  localparam logic [PAT_W-1:0] PAT_DOT_RIGHT   = 3'd1;
  localparam logic [PAT_W-1:0] PAT_BAR_LEFT    = 3'd2;
  localparam logic [PAT_W-1:0] PAT_BAR_RIGHT   = 3'd3;
  localparam logic [PAT_W-1:0] PAT_FLOWER_OUT  = 3'd4;
  localparam logic [PAT_W-1:0] PAT_FLOWER_IN   = 3'd5;

  localparam logic [STEP_W-1:0] SHIFT_LAST  = 4'd7;
  localparam logic [STEP_W-1:0] FLOWER_LAST = 4'd4;

  localparam logic [LED_W-1:0] LED_LSB      = 8'h01;
  localparam logic [LED_W-1:0] LED_MSB      = 8'h80;
  localparam logic [LED_W-1:0] LED_MID_HI   = 8'h10;
  localparam logic [LED_W-1:0] LED_MID_LO   = 8'h08;
  localparam logic [LED_W-1:0] LED_HI_HALF  = 8'hf0;
  localparam logic [LED_W-1:0] LED_LO_HALF  = 8'h0f;

endpackage

/* hdl/led_pattern_sequencer.sv */
// Channel | Dir | Signals                     | Contents
// in_     | in  | tvalid tready tdata tuser   | tuser: op; tdata: use_manual
// out_    | out | tvalid tready tdata         | tdata: led, active_pattern
// cfg_    | in  | we addr wdata               | 0 shift period, 1 flower period
//
// One request per cycle: the counter compare and the pattern step are done in
// the cycle the request is taken, the result lands in the output register.
// A full output register that is being drained still lets a new request in, so
// out_tready low is the only thing that stalls.
// Reset (synchronous, rst_n low) clears counters, step indexes and LEDs and
// loads the default periods.
module led_pattern_sequencer #(
  parameter int unsigned PATTERNS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [0] use_manual, [7:1] zero
  input  logic [0:0]  in_tuser,    // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] led, [10:8] active_pattern, [15:11] zero
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [9:0]  cfg_wdata
);

  localparam int unsigned IDX_W = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam logic [lps_pkg::PAT_W-1:0] PAT_LAST = lps_pkg::PAT_W'(PATTERNS - 1);
  localparam logic [lps_pkg::PAT_W-1:0] PAT_CNT  = lps_pkg::PAT_W'(PATTERNS);

  logic [lps_pkg::PERIOD_W-1:0] shift_period_r, flower_period_r;
  logic [lps_pkg::PERIOD_W-1:0] ms_count_r, ms_count_nxt, ms_inc;
  logic [lps_pkg::PAT_W-1:0]    auto_r, auto_nxt, manual_r, manual_nxt;
  logic [lps_pkg::STEP_W-1:0]   step_r [PATTERNS];
  logic [lps_pkg::STEP_W-1:0]   step_cur, step_nxt;
  logic [lps_pkg::LED_W-1:0]    led_r, led_nxt, led_step;
  logic                         out_valid_r;
  logic [lps_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic                         in_acc, use_manual, is_tick;
  logic [lps_pkg::PAT_W-1:0]    sel_raw, sel;
  logic [IDX_W-1:0]             sel_idx;
  logic                         flower, hit, done, step_we;
  logic [lps_pkg::PERIOD_W-1:0] period;
  logic [2:0]                   sh;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign use_manual = in_tdata[0];
  assign is_tick    = (in_tuser[0] == lps_pkg::OP_TICK);

  assign ms_inc  = (ms_count_r == lps_pkg::MS_MAX) ? ms_count_r
                                                   : ms_count_r + 10'd1;
  assign sel_raw = use_manual ? manual_r : auto_r;
  assign sel     = (sel_raw >= PAT_CNT) ? '0 : sel_raw;
  assign sel_idx = sel[IDX_W-1:0];
  assign flower  = (sel >= lps_pkg::PAT_FLOWER_OUT);
  assign period  = flower ? flower_period_r : shift_period_r;
  assign hit     = (ms_inc >= period);
  assign step_cur = step_r[sel_idx];
  assign done    = step_cur > (flower ? lps_pkg::FLOWER_LAST : lps_pkg::SHIFT_LAST);
  assign sh      = step_cur[2:0];

  always_comb begin
    case (sel)
      lps_pkg::PAT_DOT_LEFT:   led_step = lps_pkg::LED_LSB << sh;
      lps_pkg::PAT_DOT_RIGHT:  led_step = lps_pkg::LED_MSB >> sh;
      lps_pkg::PAT_BAR_LEFT:   led_step = led_r | (lps_pkg::LED_LSB << sh);
      lps_pkg::PAT_BAR_RIGHT:  led_step = led_r | (lps_pkg::LED_MSB >> sh);
      lps_pkg::PAT_FLOWER_OUT: led_step = led_r | (lps_pkg::LED_MID_HI << sh)
                                                | (lps_pkg::LED_MID_LO >> sh);
      default:                 led_step = ((lps_pkg::LED_HI_HALF >> sh) & lps_pkg::LED_HI_HALF)
                                        | ((lps_pkg::LED_LO_HALF << sh) & lps_pkg::LED_LO_HALF);
    endcase
  end

  always_comb begin
    ms_count_nxt = ms_count_r;
    auto_nxt     = auto_r;
    manual_nxt   = manual_r;
    led_nxt      = led_r;
    step_nxt     = step_cur;
    step_we      = 1'b0;
    if (is_tick) begin
      ms_count_nxt = ms_inc;
      if (hit) begin
        ms_count_nxt = '0;
        step_we      = 1'b1;
        if (done) begin
          step_nxt = '0;
          led_nxt  = '0;
          auto_nxt = (auto_r == PAT_LAST) ? '0 : auto_r + 3'd1;
        end else begin
          step_nxt = step_cur + 4'd1;
          led_nxt  = led_step;
        end
      end
    end else begin
      manual_nxt = (manual_r == PAT_LAST) ? '0 : manual_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_period_r  <= lps_pkg::SHIFT_PERIOD_RST;
      flower_period_r <= lps_pkg::FLOWER_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr[0])
        lps_pkg::CFG_SHIFT_PERIOD:  shift_period_r  <= cfg_wdata;
        lps_pkg::CFG_FLOWER_PERIOD: flower_period_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_count_r  <= '0;
      auto_r      <= '0;
      manual_r    <= '0;
      led_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < PATTERNS; k++) step_r[k] <= '0;
    end else begin
      if (in_acc) begin
        ms_count_r  <= ms_count_nxt;
        auto_r      <= auto_nxt;
        manual_r    <= manual_nxt;
        led_r       <= led_nxt;
        out_valid_r <= 1'b1;
        if (step_we) step_r[sel_idx] <= step_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {5'd0, (use_manual ? manual_nxt : auto_nxt), led_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* hdl/lps_checker.sv */
module lps_checker #(
  parameter int unsigned PATTERNS = 6
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a held result may not change under back-pressure
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // every taken request gives a result in the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("request produced no result");

  // empty output register never blocks the input
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  a_pat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[10:8] < 3'(PATTERNS)) && (out_tdata[15:11] == 5'd0))
    else $error("active pattern out of range or padding set");

endmodule

bind led_pattern_sequencer lps_checker #(.PATTERNS(PATTERNS)) u_lps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
